>>> hdl/anbs_pkg.sv
package anbs_pkg;

  // Stream byte codes
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [7:0] START_BYTE     = 8'h01;
  localparam logic [5:0] UNIT_TYPE_MASK = 6'h3F;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Start code lengths
  localparam logic [2:0] SC_LEN_NONE  = 3'd0;
  localparam logic [2:0] SC_LEN_SHORT = 3'd3;
  localparam logic [2:0] SC_LEN_LONG  = 3'd4;

  // Held zero count limit
  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

  // Group queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One group of results caused by one input word
  typedef struct packed {
    logic       end_mark;   // group is a single end-of-NAL marker
    logic [1:0] zeros;      // released zero words ahead of the data word
    logic       with_byte;  // data word follows the zeros
    logic [7:0] data;       // data word value
    logic       first;      // first payload of the group opens the NAL
    logic       long_sc;    // NAL follows a 4-byte start code
  } group_t;

endpackage

>>> hdl/anbs_front.sv
module anbs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              q_full,
  input  logic [7:0]        in_data_byte,
  output logic              q_push,
  output anbs_pkg::group_t  q_group
);
  import anbs_pkg::*;

  logic [1:0] zero_run_r, zero_run_nxt;
  logic       inside_r, inside_nxt;
  logic       has_bytes_r, has_bytes_nxt;
  logic       long_r, long_nxt;
  logic       accept;
  logic       is_zero;
  logic       is_start;
  group_t     grp;
  logic       grp_valid;

  assign accept   = in_push && !q_full;
  assign is_zero  = (in_data_byte == ZERO_BYTE);
  assign is_start = (in_data_byte == START_BYTE) && (zero_run_r >= 2'd2);

  // Classify the word and build its result group
  always_comb begin
    zero_run_nxt  = zero_run_r;
    inside_nxt    = inside_r;
    has_bytes_nxt = has_bytes_r;
    long_nxt      = long_r;
    grp           = '0;
    grp.data      = in_data_byte;
    grp.long_sc   = long_r;
    grp.first     = !has_bytes_r;
    grp_valid     = 1'b0;
    if (is_zero) begin
      if (zero_run_r < ZERO_RUN_MAX) begin
        zero_run_nxt = zero_run_r + 2'd1;
      end else begin
        // release the oldest held zero
        grp.zeros     = 2'd1;
        grp_valid     = inside_r;
        has_bytes_nxt = has_bytes_r || inside_r;
      end
    end else if (is_start) begin
      // close a non-empty NAL, open the next one
      grp.end_mark  = 1'b1;
      grp.first     = 1'b0;
      grp_valid     = inside_r && has_bytes_r;
      inside_nxt    = 1'b1;
      has_bytes_nxt = 1'b0;
      long_nxt      = (zero_run_r == ZERO_RUN_MAX);
      zero_run_nxt  = 2'd0;
    end else begin
      // flush held zeros, then the word itself
      grp.zeros     = zero_run_r;
      grp.with_byte = 1'b1;
      grp_valid     = inside_r;
      has_bytes_nxt = has_bytes_r || inside_r;
      zero_run_nxt  = 2'd0;
    end
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r  <= 2'd0;
      inside_r    <= 1'b0;
      has_bytes_r <= 1'b0;
      long_r      <= 1'b0;
    end else if (accept) begin
      zero_run_r  <= zero_run_nxt;
      inside_r    <= inside_nxt;
      has_bytes_r <= has_bytes_nxt;
      long_r      <= long_nxt;
    end
  end

  assign q_push  = accept && grp_valid;
  assign q_group = grp;

  // Held zeros are only ever released from a full run
  a_release_from_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_group.end_mark && !q_group.with_byte |-> zero_run_r == ZERO_RUN_MAX)
    else $error("zero released without a full run");

endmodule

>>> hdl/anbs_fifo.sv
module anbs_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  anbs_pkg::group_t  wr_group,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output anbs_pkg::group_t  rd_group
);
  import anbs_pkg::*;

  group_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_group = mem_r[rd_ptr_r];

  // Store incoming groups
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_group;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue fill level out of range");

endmodule

>>> hdl/anbs_back.sv
module anbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  anbs_pkg::group_t  q_group,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_kind,
  output logic [7:0]        out_payload_byte,
  output logic              out_first_of_nal,
  output logic [5:0]        out_unit_type,
  output logic [2:0]        out_start_code_length,
  output logic              out_last
);
  import anbs_pkg::*;

  group_t     cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic [2:0] total;
  logic       is_last;
  logic       advance;
  logic       load;
  logic       first_now;
  logic [7:0] byte_now;

  assign total   = {1'b0, cur_r.zeros} + {2'b00, cur_r.with_byte};
  assign is_last = cur_r.end_mark || ({1'b0, idx_r} == (total - 3'd1));
  assign advance = out_pop && cur_valid_r;
  assign load    = !cur_valid_r || (advance && is_last);
  assign q_pop   = load && q_valid;

  // Step through the current group, refill when it is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      cur_valid_r <= q_valid;
      idx_r       <= 2'd0;
    end else if (advance) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_group;
    end
  end

  // Form the word at the current position
  always_comb begin
    first_now = cur_r.first && !cur_r.end_mark && (idx_r == 2'd0);
    byte_now  = (idx_r < cur_r.zeros || cur_r.end_mark) ? ZERO_BYTE : cur_r.data;
  end

  assign out_empty             = !cur_valid_r;
  assign out_kind              = cur_r.end_mark ? KIND_END : KIND_PAYLOAD;
  assign out_payload_byte      = byte_now;
  assign out_first_of_nal      = first_now;
  assign out_unit_type         = first_now ? (byte_now[6:1] & UNIT_TYPE_MASK) : 6'd0;
  assign out_start_code_length = !first_now ? SC_LEN_NONE :
                                 (cur_r.long_sc ? SC_LEN_LONG : SC_LEN_SHORT);
  assign out_last              = is_last;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_kind == KIND_END |-> out_last)
    else $error("end marker not last of its group");

  a_first_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_first_of_nal |->
      (out_start_code_length == SC_LEN_SHORT || out_start_code_length == SC_LEN_LONG))
    else $error("first word without start code length");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && !out_last |=> !out_empty)
    else $error("group cut short");

endmodule

>>> hdl/annexb_nal_splitter_core.sv
// Channel   Handshake            Fields
// input     in_push / in_full    in_data_byte
// result    out_pop / out_empty  out_kind, out_payload_byte, out_first_of_nal,
//                                out_unit_type, out_start_code_length, out_last
//
// Takes one byte per cycle while the 4-entry group queue has room; each byte is
// classified in its accept cycle and its 0 to 4 result words go in as one group.
// Words leave one per cycle while out_pop is high; in_full is high while four
// groups wait in the queue. A byte's first word passes through the group queue
// and then the back end's current-group register before it reaches the outputs.
// rst_n is synchronous, active low; it clears parser state and queue, sets out_empty.
module annexb_nal_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_first_of_nal,
  output logic [5:0] out_unit_type,
  output logic [2:0] out_start_code_length,
  output logic       out_last
);
  import anbs_pkg::*;

  logic   q_push;
  group_t q_wr_group;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  group_t q_rd_group;

  assign in_full = q_full;

  // Classify incoming words
  anbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .q_full       (q_full),
    .in_data_byte (in_data_byte),
    .q_push       (q_push),
    .q_group      (q_wr_group)
  );

  // Decouple front and back
  anbs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_group (q_wr_group),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_group (q_rd_group)
  );

  // Serialize groups into result words
  anbs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_group               (q_rd_group),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_kind              (out_kind),
    .out_payload_byte      (out_payload_byte),
    .out_first_of_nal      (out_first_of_nal),
    .out_unit_type         (out_unit_type),
    .out_start_code_length (out_start_code_length),
    .out_last              (out_last)
  );

endmodule
